// File: hdl/mrmv_pkg.sv
// ----------------------------------------------------------------------------
// mrmv_pkg
// Shared constants and codes of the memory region map validator.
// ----------------------------------------------------------------------------
`default_nettype none

package mrmv_pkg;

	localparam int MAX_REGIONS_DEF = 64;

	localparam int ADDR_W  = 64;
	localparam int TYPE_W  = 8;
	localparam int COUNT_W = 7;

	// stored entry: {exclusive, end, start}
	localparam int ENTRY_W = 2 * ADDR_W + 1;

	localparam logic [ADDR_W-1:0] PAGE_MASK = 64'h0000_0000_0000_0fff;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_USABLE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECLAIMABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGHEST     = 2'd2;

	localparam logic [TYPE_W-1:0] USABLE_RST      = 8'd0;
	localparam logic [TYPE_W-1:0] RECLAIMABLE_RST = 8'd5;
	localparam logic [TYPE_W-1:0] HIGHEST_RST     = 8'd7;

	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_FULL      = 4'd1,
		ST_BAD_TYPE  = 4'd2,
		ST_ZERO_LEN  = 4'd3,
		ST_WRAP      = 4'd4,
		ST_UNORDERED = 4'd5,
		ST_MISALIGN  = 4'd6,
		ST_OVERLAP   = 4'd7,
		ST_USABLE_OV = 4'd8,
		ST_RECLAIM_OV = 4'd9
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CHECK = 5'b00010,
		S_SCAN  = 5'b00100,
		S_SUM   = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

endpackage

`default_nettype wire

// File: hdl/mrmv_if.sv
// ----------------------------------------------------------------------------
// mrmv channel interfaces
// Valid/ready channels for incoming regions and for per-region results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrmv_region_if;
	logic        valid;
	logic        ready;
	logic [63:0] region_base;
	logic [63:0] region_length;
	logic [7:0]  region_type;

	modport source (output valid, region_base, region_length, region_type, input ready);
	modport sink   (input valid, region_base, region_length, region_type, output ready);
endinterface

interface mrmv_result_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic [3:0]  status;
	logic [6:0]  entry_count;
	logic [63:0] usable_total;
	logic [63:0] reclaimable_total;

	modport source (output valid, accepted, status, entry_count, usable_total,
		reclaimable_total, input ready);
	modport sink   (input valid, accepted, status, entry_count, usable_total,
		reclaimable_total, output ready);
endinterface

`default_nettype wire

// File: hdl/mrmv_ram.sv
// ----------------------------------------------------------------------------
// mrmv_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module mrmv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/memory_region_map_validator.sv
// ----------------------------------------------------------------------------
// memory_region_map_validator
// Checks each offered memory region and appends good ones to a region table.
// ----------------------------------------------------------------------------
//  port     dir   transaction
//  region   in    one region: base, length, type
//  result   out   accepted, status, entry count, usable and reclaimable totals
//  cfg_*    in    type code register write, no handshake
//
//  a new region is accepted only back in idle, once the previous one is done;
//  a region rejected by the first checks skips the overlap scan; the scan reads
//  one stored entry per cycle from the single read port of the entry RAM
//  reset clears the count and totals; table contents need no clearing
//  a result waits in the output register while the next region is accepted;
//  a new result is held back until that register is free
// ----------------------------------------------------------------------------
`default_nettype none

module memory_region_map_validator
	import mrmv_pkg::*;
#(
	parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [TYPE_W-1:0]    cfg_data,
	mrmv_region_if.sink               region,
	mrmv_result_if.source             result
);

	localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CW = $clog2(MAX_REGIONS + 1);

	state_t state_q;

	logic [TYPE_W-1:0] usable_code_q, reclaim_code_q, highest_code_q;

	logic [CW-1:0]     count_q;
	logic [ADDR_W-1:0] usable_sum_q, reclaim_sum_q;
	logic [ADDR_W-1:0] last_base_q;

	// current item
	logic [ADDR_W-1:0] base_q, len_q, end_q;
	logic [TYPE_W-1:0] type_q;
	logic              is_usable_q, is_reclaim_q;
	status_t           status_q;

	// scan
	logic [CW-1:0]      scan_q;
	logic               rd_vld_s1;
	logic               hit_q;
	logic               ram_re;
	logic               ram_we;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [ENTRY_W-1:0] ram_wdata;

	// output register
	logic              out_valid_q;
	logic              out_acc_q;
	logic [3:0]        out_status_q;
	logic [COUNT_W-1:0] out_count_q;
	logic [ADDR_W-1:0] out_usable_q, out_reclaim_q;

	logic              is_usable_c, is_reclaim_c, excl_c;
	logic [ADDR_W:0]   end_sum_c;
	logic [ADDR_W:0]   usable_add_c, reclaim_add_c;
	logic              rd_excl;
	logic [ADDR_W-1:0] rd_start, rd_end;
	logic              excl_q;

	assign is_usable_c  = (type_q == usable_code_q);
	assign is_reclaim_c = !is_usable_c && (type_q == reclaim_code_q);
	assign excl_c       = (type_q == usable_code_q) || (type_q == reclaim_code_q);
	assign end_sum_c    = {1'b0, base_q} + {1'b0, len_q};
	assign excl_q       = is_usable_q || is_reclaim_q;

	assign usable_add_c  = {1'b0, usable_sum_q} + {1'b0, len_q};
	assign reclaim_add_c = {1'b0, reclaim_sum_q} + {1'b0, len_q};

	assign {rd_excl, rd_end, rd_start} = ram_rdata;

	assign ram_re    = (state_q == S_SCAN) && (scan_q < count_q);
	assign ram_we    = (state_q == S_SUM) && !hit_q
		&& !(is_usable_q && usable_add_c[ADDR_W])
		&& !(is_reclaim_q && reclaim_add_c[ADDR_W]);
	assign ram_wdata = {excl_q, end_q, base_q};

	mrmv_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_REGIONS)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IW-1:0]),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (scan_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	assign region.ready = (state_q == S_IDLE);

	assign result.valid             = out_valid_q;
	assign result.accepted          = out_acc_q;
	assign result.status            = out_status_q;
	assign result.entry_count       = out_count_q;
	assign result.usable_total      = out_usable_q;
	assign result.reclaimable_total = out_reclaim_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usable_code_q  <= USABLE_RST;
			reclaim_code_q <= RECLAIMABLE_RST;
			highest_code_q <= HIGHEST_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_USABLE:      usable_code_q  <= cfg_data;
				REG_RECLAIMABLE: reclaim_code_q <= cfg_data;
				REG_HIGHEST:     highest_code_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	// payload of the item in flight
	always_ff @(posedge clk) begin
		if (region.valid && region.ready) begin
			base_q <= region.region_base;
			len_q  <= region.region_length;
			type_q <= region.region_type;
		end
		if (state_q == S_CHECK) begin
			end_q        <= end_sum_c[ADDR_W-1:0];
			is_usable_q  <= is_usable_c;
			is_reclaim_q <= is_reclaim_c;
		end
		if (ram_we) begin
			last_base_q <= base_q;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			usable_sum_q <= '0;
			reclaim_sum_q <= '0;
			scan_q       <= '0;
			rd_vld_s1    <= 1'b0;
			hit_q        <= 1'b0;
			status_q     <= ST_OK;
			out_valid_q  <= 1'b0;
		end else begin
			// a waiting result stays until taken, a finished item loads once it is free
			out_valid_q <= (state_q == S_DONE) || (out_valid_q && !result.ready);
			unique case (state_q)
				S_IDLE: begin
					if (region.valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					scan_q    <= '0;
					rd_vld_s1 <= 1'b0;
					hit_q     <= 1'b0;
					state_q   <= S_DONE;
					if (count_q >= CW'(MAX_REGIONS)) begin
						status_q <= ST_FULL;
					end else if (type_q > highest_code_q) begin
						status_q <= ST_BAD_TYPE;
					end else if (len_q == '0) begin
						status_q <= ST_ZERO_LEN;
					end else if (end_sum_c[ADDR_W]) begin
						status_q <= ST_WRAP;
					end else if (count_q != '0 && base_q < last_base_q) begin
						status_q <= ST_UNORDERED;
					end else if (excl_c && ((base_q | len_q) & PAGE_MASK) != '0) begin
						status_q <= ST_MISALIGN;
					end else begin
						status_q <= ST_OK;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					rd_vld_s1 <= ram_re;
					if (ram_re) begin
						scan_q <= scan_q + 1'b1;
					end
					// compare the entry read in the previous cycle
					if (rd_vld_s1 && (excl_q || rd_excl)
						&& base_q < rd_end && rd_start < end_q) begin
						hit_q <= 1'b1;
					end
					if (!ram_re && !rd_vld_s1) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					state_q <= S_DONE;
					if (hit_q) begin
						status_q <= ST_OVERLAP;
					end else if (is_usable_q && usable_add_c[ADDR_W]) begin
						status_q <= ST_USABLE_OV;
					end else if (is_reclaim_q && reclaim_add_c[ADDR_W]) begin
						status_q <= ST_RECLAIM_OV;
					end else begin
						count_q <= count_q + 1'b1;
						if (is_usable_q) begin
							usable_sum_q <= usable_add_c[ADDR_W-1:0];
						end
						if (is_reclaim_q) begin
							reclaim_sum_q <= reclaim_add_c[ADDR_W-1:0];
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || result.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || result.ready)) begin
			out_acc_q     <= (status_q == ST_OK);
			out_status_q  <= status_q;
			out_count_q   <= COUNT_W'(count_q);
			out_usable_q  <= usable_sum_q;
			out_reclaim_q <= reclaim_sum_q;
		end
	end

`ifndef SYNTHESIS
	a_acc_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_acc_q == (out_status_q == ST_OK)))
		else $error("accepted flag disagrees with status");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_REGIONS))
		else $error("entry count above table size");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		($past(arst_n) && count_q != $past(count_q)) |->
		(count_q == $past(count_q) + 1'b1 && $past(ram_we)))
		else $error("entry count moved without a table write");

	a_write_clean: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (!hit_q && status_q == ST_OK && count_q < CW'(MAX_REGIONS)))
		else $error("table write for a rejected region");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (scan_q < count_q && state_q == S_SCAN))
		else $error("table read beyond stored entries");
`endif

endmodule

`default_nettype wire
